@@ design/dpb_pkg.sv @@
// Shared types and constants for the depth pixel back-projection unit.
package dpb_pkg;

	// Configuration register index and data widths
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 24;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SCALE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REJECT_BLACK = 3'd6;

	// Register reset values
	localparam logic [15:0] RST_CENTER_X     = 16'd5262;
	localparam logic [15:0] RST_CENTER_Y     = 16'd3882;
	localparam logic [23:0] RST_INV_FOCAL_X  = 24'd27894;
	localparam logic [23:0] RST_INV_FOCAL_Y  = 24'd27906;
	localparam logic [23:0] RST_DEPTH_SCALE  = 24'd16777;
	localparam logic [15:0] RST_MAX_DEPTH    = 16'd2000;
	localparam logic        RST_REJECT_BLACK = 1'b1;

	// Saturation limits of a signed Q16.16 coordinate
	localparam logic [31:0] COORD_POS_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] COORD_NEG_MAX = 32'h8000_0000;

	// Camera settings as seen by the datapath
	typedef struct packed {
		logic [15:0] center_x;
		logic [15:0] center_y;
		logic [23:0] inv_focal_x;
		logic [23:0] inv_focal_y;
		logic [23:0] depth_scale;
		logic [15:0] max_depth_raw;
		logic        reject_black;
	} dpb_cfg_t;

endpackage

@@ design/dpb_if.sv @@
// Channel interfaces: pixel input, point output and configuration write.
interface dpb_pixel_if;
	logic        valid;
	logic        ready;
	logic [11:0] column;
	logic [11:0] row;
	logic [15:0] depth_raw;
	logic [7:0]  blue;
	logic [7:0]  green;
	logic [7:0]  red;

	modport source (output valid, column, row, depth_raw, blue, green, red, input ready);
	modport sink (input valid, column, row, depth_raw, blue, green, red, output ready);
endinterface

interface dpb_point_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic [30:0]        point_z;
	logic [7:0]         out_red;
	logic [7:0]         out_green;
	logic [7:0]         out_blue;

	modport source (output valid, point_x, point_y, point_z, out_red, out_green, out_blue,
		input ready);
	modport sink (input valid, point_x, point_y, point_z, out_red, out_green, out_blue,
		output ready);
endinterface

interface dpb_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [23:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ design/dpb_cfg_regs.sv @@
// Camera configuration register file.
module dpb_cfg_regs
	import dpb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output dpb_cfg_t              cfg
);

	dpb_cfg_t cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x      <= RST_CENTER_X;
			cfg_q.center_y      <= RST_CENTER_Y;
			cfg_q.inv_focal_x   <= RST_INV_FOCAL_X;
			cfg_q.inv_focal_y   <= RST_INV_FOCAL_Y;
			cfg_q.depth_scale   <= RST_DEPTH_SCALE;
			cfg_q.max_depth_raw <= RST_MAX_DEPTH;
			cfg_q.reject_black  <= RST_REJECT_BLACK;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_CENTER_X:     cfg_q.center_x      <= wr_data[15:0];
				REG_CENTER_Y:     cfg_q.center_y      <= wr_data[15:0];
				REG_INV_FOCAL_X:  cfg_q.inv_focal_x   <= wr_data;
				REG_INV_FOCAL_Y:  cfg_q.inv_focal_y   <= wr_data;
				REG_DEPTH_SCALE:  cfg_q.depth_scale   <= wr_data;
				REG_MAX_DEPTH:    cfg_q.max_depth_raw <= wr_data[15:0];
				REG_REJECT_BLACK: cfg_q.reject_black  <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/dpb_lateral.sv @@
// Lateral coordinate pipeline: |offset| * inv_focal * depth, scaled, signed, saturated.
module dpb_lateral
	import dpb_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  logic [15:0] mag_s1,
	input  logic        neg_s1,
	input  logic [23:0] inv_f,
	input  logic [39:0] zq_s1,
	output logic [31:0] coord_s5
);

	logic [39:0] a_s2;
	logic [39:0] zq_s2;
	logic        neg_s2;
	logic [63:0] ll_s3;
	logic [39:0] lh_s3;
	logic [39:0] hl_s3;
	logic [15:0] hh_s3;
	logic        neg_s3;
	logic [79:0] prod;
	logic [43:0] m_s4;
	logic        neg_s4;

	// Stage 2: offset times inverse focal length (Q.28)
	always_ff @(posedge clk) begin
		if (en) begin
			a_s2   <= 40'(mag_s1) * 40'(inv_f);
			zq_s2  <= zq_s1;
			neg_s2 <= neg_s1;
		end
	end

	// Stage 3: 40 x 40 product split into 32-bit partial products
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s3  <= 64'(a_s2[31:0]) * 64'(zq_s2[31:0]);
			lh_s3  <= 40'(a_s2[31:0]) * 40'(zq_s2[39:32]);
			hl_s3  <= 40'(a_s2[39:32]) * 40'(zq_s2[31:0]);
			hh_s3  <= 16'(a_s2[39:32]) * 16'(zq_s2[39:32]);
			neg_s3 <= neg_s2;
		end
	end

	// Stage 4: sum of partials, truncated to Q.16
	assign prod = 80'(ll_s3) + (80'(lh_s3) << 32) + (80'(hl_s3) << 32) + (80'(hh_s3) << 64);

	always_ff @(posedge clk) begin
		if (en) begin
			m_s4   <= prod[79:36];
			neg_s4 <= neg_s3;
		end
	end

	// Stage 5: apply sign and saturate
	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s4) begin
				if (m_s4 > 44'(COORD_NEG_MAX)) begin
					coord_s5 <= COORD_NEG_MAX;
				end else begin
					coord_s5 <= 32'(~m_s4[31:0] + 32'd1);
				end
			end else begin
				if (m_s4 > 44'(COORD_POS_MAX)) begin
					coord_s5 <= COORD_POS_MAX;
				end else begin
					coord_s5 <= m_s4[31:0];
				end
			end
		end
	end

endmodule

@@ design/depth_pixel_backprojection_unit.sv @@
// Top level of the depth pixel back-projection unit.
//
//   port    direction  carries
//   ------  ---------  ----------------------------------------------------
//   pixel   in         column, row, depth_raw, blue, green, red
//   point   out        point_x, point_y, point_z, out_red/green/blue
//   cfg     in         register index and 24-bit write data
//
// One pixel per clock is accepted while the output is not held; a kept pixel passes
// five register stages (input register, focal multiply, partial products, sum,
// sign/saturate) on its way to the output.
// Rejected pixels leave no trace in the output stream.
// The whole pipeline advances together whenever the output register is empty
// or being taken; while the output is held, pixel.ready is low.
// Reset (arst_n low) clears all valid bits and loads the default camera setup.
// cfg.ready is always high; writes are meant only while the unit is idle.
module depth_pixel_backprojection_unit
	import dpb_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	dpb_pixel_if.sink   pixel,
	dpb_point_if.source point,
	dpb_cfg_if.sink     cfg
);

	dpb_cfg_t    cfg_v;
	logic        adv;
	logic        keep;
	logic [16:0] p16_x;
	logic [16:0] p16_y;

	logic        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [39:0] zq_s1;
	logic [15:0] mag_x_s1, mag_y_s1;
	logic        neg_x_s1, neg_y_s1;
	logic [23:0] rgb_s1, rgb_s2, rgb_s3, rgb_s4, rgb_s5;
	logic [30:0] z_s2, z_s3, z_s4, z_s5;
	logic [31:0] x_s5, y_s5;

	// Configuration registers
	assign cfg.ready = 1'b1;

	dpb_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_v)
	);

	// Pipeline moves as one when the output register is empty or being taken
	assign adv         = !valid_s5 || point.ready;
	assign pixel.ready = adv;

	// Pixel filter: no measurement, out of range, or black
	assign keep = (pixel.depth_raw != 16'd0) && (pixel.depth_raw <= cfg_v.max_depth_raw)
		&& !(cfg_v.reject_black && ({pixel.red, pixel.green, pixel.blue} == 24'd0));

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pixel.valid && keep;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Stage 1: depth in Q.24 metres, pixel offsets in 1/16 pixel
	assign p16_x = {1'b0, pixel.column, 4'b0000};
	assign p16_y = {1'b0, pixel.row, 4'b0000};

	always_ff @(posedge clk) begin
		if (adv) begin
			zq_s1    <= 40'(pixel.depth_raw) * 40'(cfg_v.depth_scale);
			neg_x_s1 <= {1'b0, cfg_v.center_x} > p16_x;
			neg_y_s1 <= {1'b0, cfg_v.center_y} > p16_y;
			mag_x_s1 <= ({1'b0, cfg_v.center_x} > p16_x) ? 16'(cfg_v.center_x - p16_x[15:0])
				: 16'(p16_x[15:0] - cfg_v.center_x);
			mag_y_s1 <= ({1'b0, cfg_v.center_y} > p16_y) ? 16'(cfg_v.center_y - p16_y[15:0])
				: 16'(p16_y[15:0] - cfg_v.center_y);
			rgb_s1   <= {pixel.red, pixel.green, pixel.blue};
		end
	end

	// Depth output: Q.16 with saturation, then delayed to line up with x/y
	always_ff @(posedge clk) begin
		if (adv) begin
			z_s2   <= zq_s1[39] ? COORD_POS_MAX[30:0] : zq_s1[38:8];
			z_s3   <= z_s2;
			z_s4   <= z_s3;
			z_s5   <= z_s4;
			rgb_s2 <= rgb_s1;
			rgb_s3 <= rgb_s2;
			rgb_s4 <= rgb_s3;
			rgb_s5 <= rgb_s4;
		end
	end

	// Lateral coordinates
	dpb_lateral u_lat_x (
		.clk      (clk),
		.en       (adv),
		.mag_s1   (mag_x_s1),
		.neg_s1   (neg_x_s1),
		.inv_f    (cfg_v.inv_focal_x),
		.zq_s1    (zq_s1),
		.coord_s5 (x_s5)
	);

	dpb_lateral u_lat_y (
		.clk      (clk),
		.en       (adv),
		.mag_s1   (mag_y_s1),
		.neg_s1   (neg_y_s1),
		.inv_f    (cfg_v.inv_focal_y),
		.zq_s1    (zq_s1),
		.coord_s5 (y_s5)
	);

	// Output channel
	assign point.valid     = valid_s5;
	assign point.point_x   = signed'(x_s5);
	assign point.point_y   = signed'(y_s5);
	assign point.point_z   = z_s5;
	assign point.out_red   = rgb_s5[23:16];
	assign point.out_green = rgb_s5[15:8];
	assign point.out_blue  = rgb_s5[7:0];

`ifndef SYNTHESIS
	// A pixel with no depth measurement never enters the pipeline
	assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid && pixel.ready && (pixel.depth_raw == 16'd0) |=> !valid_s1)
		else $error("zero-depth pixel entered pipeline");

	// A held output blocks the input
	assert property (@(posedge clk) disable iff (!arst_n)
		point.valid && !point.ready |-> !pixel.ready)
		else $error("input accepted while output stalled");

	// A held output keeps the pipeline frozen (checked on valid_s4, x_s5 and z_s5)
	assert property (@(posedge clk) disable iff (!arst_n)
		point.valid && !point.ready |=> $stable(valid_s4) && $stable(x_s5) && $stable(z_s5))
		else $error("pipeline moved during stall");

	// Items advance stage to stage when the pipeline moves
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s1 |=> valid_s2)
		else $error("item lost between stages");
`endif

endmodule
